### hdl/pips_pkg.sv
// Shared types, codes and widths for the strict point-in-polygon block.
`timescale 1ns / 1ps
`default_nettype none

package pips_pkg;

    // Field widths of the request and configuration channels
    localparam int COORD_W     = 32;
    localparam int INDEX_W     = 4;
    localparam int VCOUNT_W    = 5;
    localparam int EPS_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Internal arithmetic widths: offset points, edge differences, products
    localparam int PNT_W  = COORD_W + 1;
    localparam int DIFF_W = COORD_W + 2;
    localparam int PROD_W = 2 * DIFF_W;

    // Five test points: the query point and its four diagonal offsets
    localparam int NUM_LANES  = 5;
    localparam int LANE_PLAIN = 0;
    localparam int LANE_PP    = 1;
    localparam int LANE_MP    = 2;
    localparam int LANE_PM    = 3;
    localparam int LANE_MM    = 4;

    // Request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EPSILON_OFFSET = 1'd1;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd3;
    localparam logic [EPS_W-1:0]    EPS_RESET    = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CLOSE,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic wr_en;
        logic load;
        logic rd_en;
        logic rd_first;
        logic close;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

### hdl/point_in_polygon_strict.sv
// Top level of the strict point-in-polygon block: config, controller, datapath, vertex RAMs.
// After a vertex write the block stays idle and is ready again in the next cycle.
// A query walks the n vertices in use, reading one vertex per cycle; then the closing
// edge and three pipeline stages drain before the result is registered and the block
// takes the next request. With n = 0 the walk and the drain are skipped.
// A waiting result holds the next query back.
// Reset clears control state, sets vertex_count to 3 and epsilon_offset to 1; the vertex store
// is not cleared and must be written before it is queried.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_strict #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [pips_pkg::INDEX_W-1:0]        vertex_index,
    input  logic signed [pips_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pips_pkg::COORD_W-1:0] coord_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                plain_inside,
    output logic                                strict_inside,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pips_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pips_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    pips_pkg::dp_cmd_t                   cmd;
    logic [NW-1:0]                       vtx_n;
    logic [pips_pkg::EPS_W-1:0]          epsilon;
    logic                                dp_busy;
    logic [AW-1:0]                       rd_addr;
    logic [AW-1:0]                       wr_addr;
    logic signed [pips_pkg::COORD_W-1:0] rd_x;
    logic signed [pips_pkg::COORD_W-1:0] rd_y;

    assign wr_addr = AW'(vertex_index);

    pips_cfg #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vtx_n     (vtx_n),
        .epsilon   (epsilon)
    );

    pips_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (func),
        .in_index  (vertex_index),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .vtx_n     (vtx_n),
        .dp_busy   (dp_busy),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    pips_ram #(
        .DATA_W (pips_pkg::COORD_W),
        .DEPTH  (MAX_VERTICES)
    ) u_ram_x (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (coord_x),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_x)
    );

    pips_ram #(
        .DATA_W (pips_pkg::COORD_W),
        .DEPTH  (MAX_VERTICES)
    ) u_ram_y (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (coord_y),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_y)
    );

    pips_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .epsilon       (epsilon),
        .rd_x          (rd_x),
        .rd_y          (rd_y),
        .dp_busy       (dp_busy),
        .plain_inside  (plain_inside),
        .strict_inside (strict_inside)
    );

endmodule

`default_nettype wire

### hdl/pips_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pips_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [DATA_W-1:0]         wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/pips_cfg.sv
// Configuration registers: vertex count (clamped to the store depth) and offset.
`timescale 1ns / 1ps
`default_nettype none

module pips_cfg #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pips_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pips_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [$clog2(MAX_VERTICES+1)-1:0]   vtx_n,
    output logic [pips_pkg::EPS_W-1:0]          epsilon
);

    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > pips_pkg::VCOUNT_W) ? NW : pips_pkg::VCOUNT_W;

    logic [pips_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [pips_pkg::VCOUNT_W-1:0] vcount_next;
    logic [pips_pkg::EPS_W-1:0]    eps_reg;
    logic [pips_pkg::EPS_W-1:0]    eps_next;
    logic [CW-1:0]                 vcount_w;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        vcount_next = vcount_reg;
        eps_next    = eps_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pips_pkg::CFG_VERTEX_COUNT:
                    vcount_next = cfg_data[pips_pkg::VCOUNT_W-1:0];
                pips_pkg::CFG_EPSILON_OFFSET:
                    eps_next = cfg_data[pips_pkg::EPS_W-1:0];
                default:
                begin
                    vcount_next = vcount_reg;
                    eps_next    = eps_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= pips_pkg::VCOUNT_RESET;
            eps_reg    <= pips_pkg::EPS_RESET;
        end
        else
        begin
            vcount_reg <= vcount_next;
            eps_reg    <= eps_next;
        end
    end

    // A count above the store depth walks the whole store.
    assign vcount_w = CW'(vcount_reg);
    assign vtx_n    = (vcount_w > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_reg);
    assign epsilon  = eps_reg;

endmodule

`default_nettype wire

### hdl/pips_ctrl.sv
// Controller: request handshake, vertex walk sequencing and result register valid.
`timescale 1ns / 1ps
`default_nettype none

module pips_ctrl #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_func,
    input  logic [pips_pkg::INDEX_W-1:0]        in_index,
    output logic                                in_stall,
    output logic                                out_valid,
    input  logic                                out_stall,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]   vtx_n,
    input  logic                                dp_busy,
    output pips_pkg::dp_cmd_t                   cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    pips_pkg::ctrl_state_t state_reg;
    pips_pkg::ctrl_state_t state_next;
    logic [AW-1:0]         rd_addr_reg;
    logic [AW-1:0]         rd_addr_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  in_acc;
    logic                  idx_ok;
    logic                  last_read;

    assign in_stall  = (state_reg != pips_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign idx_ok    = (int'(in_index) < MAX_VERTICES);
    assign last_read = ((NW'(rd_addr_reg) + NW'(1)) == vtx_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pips_pkg::ST_IDLE;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            pips_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_func == pips_pkg::FUNC_QUERY)
                    begin
                        cmd.load     = 1'b1;
                        rd_addr_next = '0;
                        state_next   = (vtx_n == '0) ? pips_pkg::ST_DONE : pips_pkg::ST_READ;
                    end
                    else
                    begin
                        cmd.wr_en = idx_ok;
                    end
                end
            end
            pips_pkg::ST_READ:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (rd_addr_reg == '0);
                if (last_read)
                begin
                    state_next = pips_pkg::ST_CLOSE;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            pips_pkg::ST_CLOSE:
            begin
                // Closing edge from the last vertex back to vertex zero.
                cmd.close  = 1'b1;
                state_next = pips_pkg::ST_DRAIN;
            end
            pips_pkg::ST_DRAIN:
            begin
                if (!dp_busy)
                begin
                    state_next = pips_pkg::ST_DONE;
                end
            end
            pips_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pips_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pips_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign rd_addr   = rd_addr_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a waiting result");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (NW'(rd_addr_reg) < vtx_n))
        else $error("vertex read beyond the vertex count");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !dp_busy)
        else $error("new request taken while the datapath is busy");

    a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_func == pips_pkg::FUNC_QUERY) && (vtx_n != '0))
        |=> (state_reg == pips_pkg::ST_READ))
        else $error("query did not start the vertex walk");

endmodule

`default_nettype wire

### hdl/pips_dp.sv
// Datapath: five test-point lanes, edge set-up, cross-multiplied compare and parity.
`timescale 1ns / 1ps
`default_nettype none

module pips_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pips_pkg::dp_cmd_t                   cmd,
    input  logic signed [pips_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pips_pkg::COORD_W-1:0] coord_y,
    input  logic [pips_pkg::EPS_W-1:0]          epsilon,
    input  logic signed [pips_pkg::COORD_W-1:0] rd_x,
    input  logic signed [pips_pkg::COORD_W-1:0] rd_y,
    output logic                                dp_busy,
    output logic                                plain_inside,
    output logic                                strict_inside
);

    localparam int NL = pips_pkg::NUM_LANES;

    // Test points, loaded when a query is taken
    logic signed [pips_pkg::PNT_W-1:0]  px_reg [NL];
    logic signed [pips_pkg::PNT_W-1:0]  py_reg [NL];
    logic signed [pips_pkg::PNT_W-1:0]  x_w;
    logic signed [pips_pkg::PNT_W-1:0]  y_w;
    logic signed [pips_pkg::PNT_W-1:0]  e_w;

    // Read data alignment and stored vertices
    logic                                rd_d_reg;
    logic                                first_d_reg;
    logic                                close_d_reg;
    logic signed [pips_pkg::COORD_W-1:0] v0_x_reg;
    logic signed [pips_pkg::COORD_W-1:0] v0_y_reg;
    logic signed [pips_pkg::COORD_W-1:0] prev_x_reg;
    logic signed [pips_pkg::COORD_W-1:0] prev_y_reg;
    logic signed [pips_pkg::COORD_W-1:0] edge_bx;
    logic signed [pips_pkg::COORD_W-1:0] edge_by;
    logic signed [pips_pkg::DIFF_W-1:0]  xi_w;
    logic signed [pips_pkg::DIFF_W-1:0]  yi_w;
    logic signed [pips_pkg::DIFF_W-1:0]  xj_w;
    logic signed [pips_pkg::DIFF_W-1:0]  yj_w;
    logic                                e_valid;

    // Edge stage
    logic                                s1_valid_reg;
    logic [NL-1:0]                       strad1_reg;
    logic signed [pips_pkg::DIFF_W-1:0]  a_reg  [NL];
    logic signed [pips_pkg::DIFF_W-1:0]  dy_reg [NL];
    logic signed [pips_pkg::DIFF_W-1:0]  rx_reg [NL];
    logic signed [pips_pkg::DIFF_W-1:0]  ry_reg [NL];

    // Product stage
    logic                                s2_valid_reg;
    logic [NL-1:0]                       strad2_reg;
    logic [NL-1:0]                       dpos_reg;
    logic signed [pips_pkg::PROD_W-1:0]  p1_reg [NL];
    logic signed [pips_pkg::PROD_W-1:0]  p2_reg [NL];

    logic [NL-1:0]                       hit_vec;
    logic [NL-1:0]                       par_reg;
    logic                                plain_reg;
    logic                                strict_reg;

    assign x_w = pips_pkg::PNT_W'(coord_x);
    assign y_w = pips_pkg::PNT_W'(coord_y);
    assign e_w = signed'(pips_pkg::PNT_W'(epsilon));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg[pips_pkg::LANE_PLAIN] <= x_w;
            py_reg[pips_pkg::LANE_PLAIN] <= y_w;
            px_reg[pips_pkg::LANE_PP]    <= x_w + e_w;
            py_reg[pips_pkg::LANE_PP]    <= y_w + e_w;
            px_reg[pips_pkg::LANE_MP]    <= x_w - e_w;
            py_reg[pips_pkg::LANE_MP]    <= y_w + e_w;
            px_reg[pips_pkg::LANE_PM]    <= x_w + e_w;
            py_reg[pips_pkg::LANE_PM]    <= y_w - e_w;
            px_reg[pips_pkg::LANE_MM]    <= x_w - e_w;
            py_reg[pips_pkg::LANE_MM]    <= y_w - e_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_d_reg     <= 1'b0;
            first_d_reg  <= 1'b0;
            close_d_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            par_reg      <= '0;
        end
        else
        begin
            rd_d_reg     <= cmd.rd_en;
            first_d_reg  <= cmd.rd_first;
            close_d_reg  <= cmd.close;
            s1_valid_reg <= e_valid;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.load)
            begin
                par_reg <= '0;
            end
            else
            begin
                par_reg <= par_reg ^ hit_vec;
            end
        end
    end

    // The first vertex read only primes the walk; every later one ends an edge.
    assign e_valid = (rd_d_reg && !first_d_reg) || close_d_reg;
    assign edge_bx = close_d_reg ? v0_x_reg : rd_x;
    assign edge_by = close_d_reg ? v0_y_reg : rd_y;
    assign xi_w    = pips_pkg::DIFF_W'(prev_x_reg);
    assign yi_w    = pips_pkg::DIFF_W'(prev_y_reg);
    assign xj_w    = pips_pkg::DIFF_W'(edge_bx);
    assign yj_w    = pips_pkg::DIFF_W'(edge_by);

    always_ff @(posedge clk)
    begin
        if (rd_d_reg)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (first_d_reg)
            begin
                v0_x_reg <= rd_x;
                v0_y_reg <= rd_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_valid)
        begin
            for (int l = 0; l < NL; l++)
            begin
                strad1_reg[l] <= (yi_w > pips_pkg::DIFF_W'(py_reg[l]))
                              != (yj_w > pips_pkg::DIFF_W'(py_reg[l]));
                a_reg[l]      <= pips_pkg::DIFF_W'(px_reg[l]) - xi_w;
                dy_reg[l]     <= yj_w - yi_w;
                rx_reg[l]     <= xj_w - xi_w;
                ry_reg[l]     <= pips_pkg::DIFF_W'(py_reg[l]) - yi_w;
            end
        end
    end

    // px < xi + rx*ry/dy, multiplied through by dy; the sign of dy sets the direction.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int l = 0; l < NL; l++)
            begin
                p1_reg[l]     <= pips_pkg::PROD_W'(a_reg[l]) * pips_pkg::PROD_W'(dy_reg[l]);
                p2_reg[l]     <= pips_pkg::PROD_W'(rx_reg[l]) * pips_pkg::PROD_W'(ry_reg[l]);
                dpos_reg[l]   <= !dy_reg[l][pips_pkg::DIFF_W-1] && (dy_reg[l] != '0);
                strad2_reg[l] <= strad1_reg[l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            hit_vec[l] = s2_valid_reg && strad2_reg[l]
                      && (dpos_reg[l] ? (p1_reg[l] < p2_reg[l]) : (p2_reg[l] < p1_reg[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            plain_reg  <= par_reg[pips_pkg::LANE_PLAIN];
            strict_reg <= par_reg[pips_pkg::LANE_PP] && par_reg[pips_pkg::LANE_MP]
                       && par_reg[pips_pkg::LANE_PM] && par_reg[pips_pkg::LANE_MM];
        end
    end

    assign dp_busy       = rd_d_reg || close_d_reg || s1_valid_reg || s2_valid_reg;
    assign plain_inside  = plain_reg;
    assign strict_inside = strict_reg;

endmodule

`default_nettype wire

### test/pips_result_checker.sv
// Checker for the strict point-in-polygon block: predicts each query verdict and compares it.
`timescale 1ns / 1ps

module pips_result_checker #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                func,
    input  logic [pips_pkg::INDEX_W-1:0]        vertex_index,
    input  logic signed [pips_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pips_pkg::COORD_W-1:0] coord_y,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                plain_inside,
    input  logic                                strict_inside,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pips_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pips_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    import pips_pkg::*;

    typedef struct packed {
        logic plain;
        logic strict_all;
    } verdict_t;

    logic signed [COORD_W-1:0] vx_store [MAX_VERTICES];
    logic signed [COORD_W-1:0] vy_store [MAX_VERTICES];
    logic [VCOUNT_W-1:0]       vcount;
    logic [EPS_W-1:0]          eps;
    verdict_t                  verdict_q [$];
    verdict_t                  want;
    int                        errors;

    // Exact a*b < c*d; the operands never exceed 35 bits, so 128 bits cannot overflow.
    function automatic logic product_less(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        return (wa * wb) < (wc * wd);
    endfunction

    function automatic logic crossing_parity(longint px, longint py);
        int     n, i, j;
        logic   odd;
        logic   hit;
        longint xi, yi, xj, yj, dy;
        n = vcount;
        if (n > MAX_VERTICES)
            n = MAX_VERTICES;
        odd = 1'b0;
        for (i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            xi = vx_store[i];
            yi = vy_store[i];
            xj = vx_store[j];
            yj = vy_store[j];
            if ((yi > py) != (yj > py))
            begin
                // The crossing test is multiplied through by dy, so its sign flips the order.
                dy = yj - yi;
                if (dy > 0)
                    hit = product_less(px - xi, dy, xj - xi, py - yi);
                else
                    hit = product_less(xj - xi, py - yi, px - xi, dy);
                if (hit)
                    odd = !odd;
            end
        end
        return odd;
    endfunction

    function automatic verdict_t predict_verdict(longint px, longint py);
        verdict_t v;
        longint   e;
        e = eps;
        v.plain = crossing_parity(px, py);
        v.strict_all = crossing_parity(px + e, py + e) && crossing_parity(px - e, py + e) &&
                       crossing_parity(px + e, py - e) && crossing_parity(px - e, py - e);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount = VCOUNT_RESET;
            eps = EPS_RESET;
            verdict_q.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: plain=%0b strict=%0b",
                                 plain_inside, strict_inside);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (want.plain !== plain_inside || want.strict_all !== strict_inside)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected plain=%0b strict=%0b, got plain=%0b strict=%0b",
                                     want.plain, want.strict_all, plain_inside, strict_inside);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_VERTEX_COUNT)
                    vcount = cfg_data[VCOUNT_W-1:0];
                else if (cfg_index == CFG_EPSILON_OFFSET)
                    eps = cfg_data[EPS_W-1:0];
            end

            if (in_valid && !in_stall)
            begin
                if (func == FUNC_WRITE)
                begin
                    if (vertex_index < MAX_VERTICES)
                    begin
                        vx_store[vertex_index] = coord_x;
                        vy_store[vertex_index] = coord_y;
                    end
                end
                else
                    verdict_q.insert(verdict_q.size(), predict_verdict(coord_x, coord_y));
            end

            fail_count <= errors;
            pending <= verdict_q.size();
        end
    end

endmodule

### test/point_in_polygon_strict_tb.sv
// Testbench top for the strict point-in-polygon block: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module point_in_polygon_strict_tb;
    import pips_pkg::*;

    localparam int     MAX_VERTICES  = 16;
    localparam int     LIMIT_CYCLES  = 500000;
    localparam int     NUM_PHASES    = 10;
    localparam int     PHASE_ITEMS   = 48;
    localparam int     SETTLE_CYCLES = 40;
    localparam longint COORD_MIN     = -(longint'(1) <<< 31);
    localparam longint COORD_MAX     = (longint'(1) <<< 31) - 1;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_stall;
    logic                       func          = FUNC_WRITE;
    logic [INDEX_W-1:0]         vertex_index  = '0;
    logic signed [COORD_W-1:0]  coord_x       = '0;
    logic signed [COORD_W-1:0]  coord_y       = '0;
    logic                       out_valid;
    logic                       out_stall     = 1'b0;
    logic                       plain_inside;
    logic                       strict_inside;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index     = '0;
    logic [CFG_DATA_W-1:0]      cfg_data      = '0;

    int     fail_count;
    int     pending;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    longint shadow_x [MAX_VERTICES];
    longint shadow_y [MAX_VERTICES];

    point_in_polygon_strict #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_inside (plain_inside),
        .strict_inside(strict_inside),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pips_result_checker #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_inside (plain_inside),
        .strict_inside(strict_inside),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic longint rand_span(int k);
        int r;
        r = $urandom;
        return longint'(r >>> (32 - k));
    endfunction

    function automatic longint rand_jitter(int j);
        return longint'($urandom_range(0, 2 * j)) - j;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        else if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    // Random idle cycles come before the request; a stalled request holds its payload.
    task automatic send_request(input logic f, input logic [INDEX_W-1:0] idx,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        vertex_index <= idx;
        coord_x <= x;
        coord_y <= y;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_vertex(input int slot, input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
        shadow_x[slot] = x;
        shadow_y[slot] = y;
        send_request(FUNC_WRITE, INDEX_W'(slot), x, y);
    endtask

    task automatic query_point(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        send_request(FUNC_QUERY, INDEX_W'($urandom_range(0, 15)), x, y);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every query has its result and the walk has surely finished.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
            @(posedge clk);
        $display("point_in_polygon_strict_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        int         p, s, t, k, n_eff, cnt, item, j;
        longint     cx, cy, px, py;
        logic [15:0] eps_val;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: three vertices and the smallest non-zero offset.
        write_vertex(0, 32'sh80000000, 32'sh80000000);
        write_vertex(1, 32'sh7FFFFFFF, 32'sh80000000);
        write_vertex(2, 32'sh00000000, 32'sh7FFFFFFF);
        query_point(32'sh00000000, 32'sh00000000);
        query_point(32'sh80000000, 32'sh80000000);
        query_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        query_point(32'sh00000000, 32'sh80000000);
        query_point(32'shFFFFFFFF, 32'shFFFFFFFF);
        query_point(32'sh7FFFFFFF, 32'sh80000000);
        query_point(32'sh80000000, 32'sh7FFFFFFF);
        write_vertex(15, 32'shFFFFFFFF, 32'shFFFFFFFF);

        // Largest offset: points near the outer edges are no longer strictly inside, and
        // the offset points reach beyond the 32-bit range without wrapping.
        settle();
        write_register(CFG_EPSILON_OFFSET, 16'hFFFF);
        query_point(32'sh00000000, 32'sh00000000);
        query_point(32'sh00000000, 32'sh8000FFFF);
        query_point(32'sh00000000, 32'sh7FFDFFFF);
        query_point(32'sh7FFFFFFF, 32'sh80000000);

        // Unit triangle in Q16.16.
        write_vertex(0, 32'sh00000000, 32'sh00000000);
        write_vertex(1, 32'sh00010000, 32'sh00000000);
        write_vertex(2, 32'sh00000000, 32'sh00010000);
        query_point(32'sh00004000, 32'sh00004000);
        settle();
        write_register(CFG_EPSILON_OFFSET, 16'h0000);
        query_point(32'sh00004000, 32'sh00004000);
        query_point(32'sh00000000, 32'sh00000000);
        query_point(32'sh00008000, 32'sh00008000);

        // Every slot holds a vertex before any count above three is used.
        for (s = 0; s < MAX_VERTICES; s++)
            write_vertex(s, $urandom, $urandom);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase

            // Counts of zero, one and two are degenerate; counts above sixteen saturate.
            case (p)
                0: cnt = 16;
                1: cnt = 0;
                2: cnt = 1;
                3: cnt = 2;
                4: cnt = 31;
                5: cnt = 4;
                6: cnt = 3;
                7: cnt = 17;
                8: cnt = $urandom_range(3, 16);
                default: cnt = 8;
            endcase
            case (p)
                0, 6: eps_val = 16'h0000;
                1, 7: eps_val = 16'hFFFF;
                2: eps_val = 16'h0001;
                3: eps_val = 16'($urandom_range(0, 255));
                9: eps_val = 16'd300;
                default: eps_val = 16'($urandom);
            endcase
            write_register(CFG_VERTEX_COUNT, {11'($urandom_range(0, 2047)), 5'(cnt)});
            write_register(CFG_EPSILON_OFFSET, eps_val);

            n_eff = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
            case ($urandom_range(0, 6))
                0: k = 8;
                1: k = 16;
                2: k = 20;
                3: k = 24;
                4: k = 28;
                5: k = 31;
                default: k = 32;
            endcase
            cx = rand_span($urandom_range(1, 32));
            cy = rand_span($urandom_range(1, 32));
            j = 2 * int'(eps_val) + 2;
            for (s = 0; s < n_eff; s++)
                write_vertex(s, clamp_coord(cx + rand_span(k)), clamp_coord(cy + rand_span(k)));

            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                s = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : $urandom_range(0, 15);
                if ($urandom_range(0, 99) < 15)
                begin
                    // Noise: a stray vertex write that may reshape the polygon.
                    if ($urandom_range(0, 1) == 0)
                        write_vertex($urandom_range(0, 15), $urandom, $urandom);
                    else
                        write_vertex($urandom_range(0, 15), clamp_coord(cx + rand_span(k)),
                                     clamp_coord(cy + rand_span(k)));
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            px = shadow_x[s];
                            py = shadow_y[s];
                        end
                        1:
                        begin
                            px = shadow_x[s] + rand_jitter(j);
                            py = shadow_y[s] + rand_jitter(j);
                        end
                        2:
                        begin
                            if (n_eff > 0)
                                t = (s + 1 == n_eff) ? 0 : s + 1;
                            else
                                t = (s + 1) % MAX_VERTICES;
                            px = ((shadow_x[s] + shadow_x[t]) >>> 1) + rand_jitter(j);
                            py = ((shadow_y[s] + shadow_y[t]) >>> 1) + rand_jitter(j);
                        end
                        3:
                        begin
                            px = cx + rand_span(k);
                            py = cy + rand_span(k);
                        end
                        default:
                        begin
                            px = rand_span(32);
                            py = rand_span(32);
                        end
                    endcase
                    query_point(clamp_coord(px), clamp_coord(py));
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("point_in_polygon_strict_tb passed");
        else
            $display("point_in_polygon_strict_tb failed");
        $finish;
    end

endmodule
